// ===== hdl/pfa_pkg.sv =====
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared widths, constants and payload types of the pitot airspeed core.
// ----------------------------------------------------------------------------
package pfa_pkg;

    localparam int PRESSURE_BITS = 14;
    localparam int TEMP_BITS     = 11;

    localparam int CFG_W     = 18;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOD    = 2'd2;

    localparam logic [CFG_W-1:0] GAIN_RESET   = 18'd72660;
    localparam logic [CFG_W-1:0] OFFSET_RESET = 18'd145128;
    localparam logic [CFG_W-1:0] TOD_RESET    = 18'd112993;

    localparam int FRAME_W = 32;
    localparam int SPEED_W = 16;
    localparam int TEMP_W  = 13;
    localparam int PRESS_W = 20;

    // temperature: round_half_up(6400*t / (2*TMAX)) - 800
    localparam longint TMAX      = (64'd1 << TEMP_BITS) - 1;
    localparam longint T_DIV     = 2 * TMAX;
    localparam longint T_SCALE   = 6400;
    localparam longint T_OFFSET  = 800;
    localparam longint T_NUM_MAX = T_SCALE * TMAX + TMAX;
    localparam int     T_NUM_W   = $clog2(T_NUM_MAX + 1);
    localparam longint T_RECIP   = (64'd1 << T_NUM_W) / T_DIV;
    localparam int     T_RECIP_W = $clog2(T_RECIP + 1);
    localparam int     T_Q_W     = 12;

    // pressure: offset - round_half_up(gain*count / 4096)
    localparam int     P_SHIFT  = 12;
    localparam longint P_ROUND  = 64'd1 << (P_SHIFT - 1);
    localparam int     P_PROD_W = CFG_W + PRESSURE_BITS;
    localparam int     P_DROP_W = P_PROD_W + 1 - P_SHIFT;
    localparam int     P_WIDE_W = P_DROP_W + 2;

    // airspeed: floor(sqrt((P * 2/rho) >> 4))
    localparam int X_SHIFT   = 4;
    localparam int X_PROD_W  = (PRESS_W - 1) + CFG_W;
    localparam int X_W       = X_PROD_W - X_SHIFT;
    localparam int ROOT_W    = (X_W + 1) / 2;
    localparam int X_PAD_W   = 2 * ROOT_W;
    localparam int REM_W     = ROOT_W + 2;
    localparam int REM_EXT_W = REM_W + 2;

    typedef struct packed {
        logic signed [TEMP_W-1:0]  temperature;
        logic signed [PRESS_W-1:0] pressure;
        logic                      flow_valid;
    } pfa_side_t;

    typedef struct packed {
        logic [X_PAD_W-1:0] x;
        logic [REM_W-1:0]   rem;
        logic [ROOT_W-1:0]  root;
        pfa_side_t          side;
    } pfa_sqrt_t;

endpackage

// ===== hdl/pfa_front.sv =====
// ----------------------------------------------------------------------------
// pfa_front
// Frame decode, temperature scaling, pressure calibration and the radicand
// product, in three stages ahead of the square-root chain.
// ----------------------------------------------------------------------------
module pfa_front
    import pfa_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [CFG_W-1:0]   gain,
    input  logic [CFG_W-1:0]   offset,
    input  logic [CFG_W-1:0]   two_over_density,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [FRAME_W-1:0] s_raw_frame,
    output logic               out_valid,
    input  logic               out_ready,
    output pfa_sqrt_t          out_data
);

    logic v1_reg, v2_reg, v3_reg;
    logic adv1, adv2, adv3;

    logic [T_NUM_W-1:0]  n1_reg, n2_reg;
    logic [P_PROD_W-1:0] pprod1_reg;
    logic [T_Q_W-1:0]    tq2_reg;
    logic signed [PRESS_W-1:0] press2_reg, press3_reg;
    logic signed [TEMP_W-1:0]  temp3_reg;
    logic [X_PROD_W-1:0] xprod3_reg;
    logic                flow3_reg;

    logic [TEMP_BITS-1:0]     tcount;
    logic [PRESSURE_BITS-1:0] pcount;
    logic [T_NUM_W-1:0]       n1_next;
    logic [P_PROD_W-1:0]      pprod1_next;

    logic [T_NUM_W+T_RECIP_W-1:0] t_prod;
    logic [T_Q_W-1:0]             tq2_next;
    logic [P_DROP_W-1:0]          drop;
    logic signed [P_WIDE_W-1:0]   press_wide;
    logic signed [PRESS_W-1:0]    press2_next;

    logic [T_NUM_W-1:0]        t_rem;
    logic [T_Q_W-1:0]          tq_fin;
    logic signed [TEMP_W-1:0]  temp3_next;
    logic                      flow3_next;
    logic [X_PROD_W-1:0]       xprod3_next;

    assign adv3    = !v3_reg || out_ready;
    assign adv2    = !v2_reg || adv3;
    assign adv1    = !v1_reg || adv2;
    assign s_ready = adv1;

    // stage 1
    assign tcount      = s_raw_frame[15 -: TEMP_BITS];
    assign pcount      = s_raw_frame[16 +: PRESSURE_BITS];
    assign n1_next     = T_NUM_W'(tcount) * T_NUM_W'(T_SCALE) + T_NUM_W'(TMAX);
    assign pprod1_next = P_PROD_W'(gain) * P_PROD_W'(pcount);

    // stage 2
    assign t_prod   = (T_NUM_W+T_RECIP_W)'(n1_reg) * (T_NUM_W+T_RECIP_W)'(T_RECIP);
    assign tq2_next = T_Q_W'(t_prod >> T_NUM_W);
    assign drop     = P_DROP_W'(((P_PROD_W+1)'(pprod1_reg) + (P_PROD_W+1)'(P_ROUND))
                                >> P_SHIFT);
    assign press_wide = $signed(P_WIDE_W'(offset)) - $signed(P_WIDE_W'(drop));

    always_comb begin
        if (press_wide[P_WIDE_W-1:PRESS_W-1] == '0 ||
            press_wide[P_WIDE_W-1:PRESS_W-1] == '1) begin
            press2_next = press_wide[PRESS_W-1:0];
        end else if (press_wide[P_WIDE_W-1]) begin
            press2_next = {1'b1, {(PRESS_W-1){1'b0}}};
        end else begin
            press2_next = {1'b0, {(PRESS_W-1){1'b1}}};
        end
    end

    // stage 3: reciprocal estimate is low by at most one
    assign t_rem  = n2_reg - T_NUM_W'(tq2_reg * T_DIV);
    assign tq_fin = (t_rem >= T_NUM_W'(T_DIV)) ? tq2_reg + T_Q_W'(1) : tq2_reg;
    assign temp3_next = $signed(TEMP_W'(tq_fin) - TEMP_W'(T_OFFSET));
    assign flow3_next = !press2_reg[PRESS_W-1] && (|press2_reg);
    assign xprod3_next = flow3_next
        ? X_PROD_W'(press2_reg[PRESS_W-2:0]) * X_PROD_W'(two_over_density)
        : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (adv1) begin
                v1_reg <= s_valid;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
            if (adv3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            n1_reg     <= n1_next;
            pprod1_reg <= pprod1_next;
        end
        if (adv2) begin
            n2_reg     <= n1_reg;
            tq2_reg    <= tq2_next;
            press2_reg <= press2_next;
        end
        if (adv3) begin
            temp3_reg  <= temp3_next;
            press3_reg <= press2_reg;
            flow3_reg  <= flow3_next;
            xprod3_reg <= xprod3_next;
        end
    end

    assign out_valid                  = v3_reg;
    assign out_data.x                 = X_PAD_W'(xprod3_reg[X_PROD_W-1:X_SHIFT]);
    assign out_data.rem               = '0;
    assign out_data.root              = '0;
    assign out_data.side.temperature  = temp3_reg;
    assign out_data.side.pressure     = press3_reg;
    assign out_data.side.flow_valid   = flow3_reg;

endmodule

// ===== hdl/pfa_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// pfa_sqrt_cell
// One digit of a restoring square root: takes two radicand bits, settles one
// root bit, and passes the partial result on to the next cell.
// ----------------------------------------------------------------------------
module pfa_sqrt_cell
    import pfa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  pfa_sqrt_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output pfa_sqrt_t out_data
);

    logic      valid_reg;
    pfa_sqrt_t data_reg;
    pfa_sqrt_t data_next;

    logic [REM_EXT_W-1:0] cur;
    logic [REM_EXT_W-1:0] trial;

    assign in_ready = !valid_reg || out_ready;

    assign cur   = {in_data.rem, in_data.x[X_PAD_W-1 -: 2]};
    assign trial = REM_EXT_W'({in_data.root, 2'b01});

    always_comb begin
        data_next      = in_data;
        data_next.x    = in_data.x << 2;
        if (cur >= trial) begin
            data_next.rem  = REM_W'(cur - trial);
            data_next.root = {in_data.root[ROOT_W-2:0], 1'b1};
        end else begin
            data_next.rem  = REM_W'(cur);
            data_next.root = {in_data.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hdl/pitot_frame_to_airspeed_core.sv =====
// ----------------------------------------------------------------------------
// pitot_frame_to_airspeed_core
// Converts one differential-pressure sensor frame into temperature, pressure
// and pitot airspeed.
//
//   channel  dir  handshake          payload
//   s_       in   s_valid/s_ready    s_raw_frame
//   m_       out  m_valid/m_ready    m_airspeed_q8, m_temperature_q4,
//                                    m_pressure_q4, m_flow_valid
//   cfg_     in   cfg_we             cfg_index, cfg_wdata
//
// One frame per cycle while m_ready does not stall; the pipeline is three
// calibration stages, one cell per root bit (17) and the output register.
// Every stage has its own valid bit, so bubbles close up under m_ready stalls.
// Synchronous active-low reset clears valid bits and restores the config registers.
// ----------------------------------------------------------------------------
module pitot_frame_to_airspeed_core
    import pfa_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]          cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [FRAME_W-1:0]        s_raw_frame,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [SPEED_W-1:0]        m_airspeed_q8,
    output logic signed [TEMP_W-1:0]  m_temperature_q4,
    output logic signed [PRESS_W-1:0] m_pressure_q4,
    output logic                      m_flow_valid
);

    logic [CFG_W-1:0] gain_reg, offset_reg, tod_reg;

    logic [ROOT_W:0] cell_valid;
    logic [ROOT_W:0] cell_ready;
    pfa_sqrt_t       cell_data [0:ROOT_W];

    logic                      m_valid_reg;
    logic [SPEED_W-1:0]        speed_reg;
    logic signed [TEMP_W-1:0]  temp_reg;
    logic signed [PRESS_W-1:0] press_reg;
    logic                      flow_reg;
    logic                      out_adv;
    logic [SPEED_W-1:0]        speed_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg   <= GAIN_RESET;
            offset_reg <= OFFSET_RESET;
            tod_reg    <= TOD_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_GAIN:   gain_reg   <= cfg_wdata;
                REG_OFFSET: offset_reg <= cfg_wdata;
                REG_TOD:    tod_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    pfa_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .gain             (gain_reg),
        .offset           (offset_reg),
        .two_over_density (tod_reg),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_raw_frame      (s_raw_frame),
        .out_valid        (cell_valid[0]),
        .out_ready        (cell_ready[0]),
        .out_data         (cell_data[0])
    );

    for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
        pfa_sqrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (cell_valid[i]),
            .in_ready  (cell_ready[i]),
            .in_data   (cell_data[i]),
            .out_valid (cell_valid[i+1]),
            .out_ready (cell_ready[i+1]),
            .out_data  (cell_data[i+1])
        );
    end

    assign out_adv            = !m_valid_reg || m_ready;
    assign cell_ready[ROOT_W] = out_adv;

    assign speed_next = (|cell_data[ROOT_W].root[ROOT_W-1:SPEED_W])
                      ? {SPEED_W{1'b1}}
                      : cell_data[ROOT_W].root[SPEED_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_adv) begin
            m_valid_reg <= cell_valid[ROOT_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv) begin
            speed_reg <= speed_next;
            temp_reg  <= cell_data[ROOT_W].side.temperature;
            press_reg <= cell_data[ROOT_W].side.pressure;
            flow_reg  <= cell_data[ROOT_W].side.flow_valid;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_airspeed_q8    = speed_reg;
    assign m_temperature_q4 = temp_reg;
    assign m_pressure_q4    = press_reg;
    assign m_flow_valid     = flow_reg;

endmodule
